// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the packer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== hw/rtl/tpbp_pkg.sv =====
// Package for the tracker pattern bit packer: command codes, widths, effect table
package tpbp_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned BitsW   = 32;
  localparam int unsigned LenW    = 5;
  localparam int unsigned AccW    = 40;
  localparam int unsigned WordW   = 32;
  localparam int unsigned BeatW   = 3;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CmdW-1:0] {
    CMD_RESTART = 3'd0,
    CMD_CHUNK   = 3'd1,
    CMD_SONG    = 3'd2,
    CMD_INSTR   = 3'd3,
    CMD_TRACK   = 3'd4,
    CMD_ALIGN   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [BitsW-1:0] bits;
    logic [LenW-1:0]  len;
  } enc_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [BeatW-1:0] beats;
    logic             has_byte;
  } load_t;

  // Position of an effect character in "0dfijlmtvw~+=", 0 if absent
  function automatic logic [3:0] effect_index(logic [7:0] ch);
    logic [3:0] idx;
    case (ch)
      8'h30:   idx = 4'd0;
      8'h64:   idx = 4'd1;
      8'h66:   idx = 4'd2;
      8'h69:   idx = 4'd3;
      8'h6A:   idx = 4'd4;
      8'h6C:   idx = 4'd5;
      8'h6D:   idx = 4'd6;
      8'h74:   idx = 4'd7;
      8'h76:   idx = 4'd8;
      8'h77:   idx = 4'd9;
      8'h7E:   idx = 4'd10;
      8'h2B:   idx = 4'd11;
      8'h3D:   idx = 4'd12;
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

endpackage

// ===== hw/rtl/tpbp_encode.sv =====
// Record formatter: turns one record into an LSB-first bit string and its length
module tpbp_encode (
  input  tpbp_pkg::cmd_e cmd_i,
  input  logic [15:0]    chunk_data_i,
  input  logic [4:0]     chunk_width_i,
  input  logic [7:0]     pattern_i,
  input  logic [7:0]     transpose_i,
  input  logic [6:0]     note_i,
  input  logic [7:0]     instrument_i,
  input  logic [7:0]     effect_char_i,
  input  logic [7:0]     effect_param_i,
  input  logic [2:0]     pend_cnt_i,
  output tpbp_pkg::enc_t enc_o
);

  logic [3:0]                 idx;
  logic [4:0]                 width;
  logic                       f_note;
  logic                       f_ins;
  logic                       f_eff;
  logic                       f_tr;
  logic [tpbp_pkg::LenW-1:0]  pos;
  logic [tpbp_pkg::BitsW-1:0] bits;

  assign idx    = tpbp_pkg::effect_index(effect_char_i);
  assign width  = (chunk_width_i > 5'd16) ? 5'd16 : chunk_width_i;
  assign f_note = (note_i != 7'd0);
  assign f_ins  = (instrument_i != 8'd0);
  assign f_eff  = (idx != 4'd0);
  // song entry flag bit
  assign f_tr   = (transpose_i != 8'd0);

  always_comb begin
    bits = '0;
    pos  = '0;
    unique case (cmd_i)
      tpbp_pkg::CMD_CHUNK: begin
        bits = tpbp_pkg::BitsW'(chunk_data_i & ~(16'hFFFF << width));
        pos  = width;
      end
      tpbp_pkg::CMD_SONG: begin
        bits = tpbp_pkg::BitsW'({pattern_i[5:0], f_tr});
        pos  = 5'd7;
        if (f_tr) begin
          bits = bits | (tpbp_pkg::BitsW'(transpose_i[3:0]) << 7);
          pos  = 5'd11;
        end
      end
      tpbp_pkg::CMD_INSTR: begin
        bits = tpbp_pkg::BitsW'({effect_param_i, 4'd0, idx});
        pos  = 5'd16;
      end
      tpbp_pkg::CMD_TRACK: begin
        bits = tpbp_pkg::BitsW'({f_eff, f_ins, f_note});
        pos  = 5'd3;
        if (f_note) begin
          bits = bits | (tpbp_pkg::BitsW'(note_i) << pos);
          pos  = pos + 5'd7;
        end
        if (f_ins) begin
          bits = bits | (tpbp_pkg::BitsW'(instrument_i[3:0]) << pos);
          pos  = pos + 5'd4;
        end
        if (f_eff) begin
          bits = bits | (tpbp_pkg::BitsW'({effect_param_i, idx}) << pos);
          pos  = pos + 5'd12;
        end
      end
      tpbp_pkg::CMD_ALIGN: begin
        pos = tpbp_pkg::LenW'(3'(3'd0 - pend_cnt_i));
      end
      default: begin
        bits = '0;
        pos  = '0;
      end
    endcase
  end

  assign enc_o.bits = bits;
  assign enc_o.len  = pos;

endmodule

// ===== hw/rtl/tpbp_emit.sv =====
// Result register: holds up to four completed bytes and sends them one per cycle while the receiver is ready
`include "assert_macros.svh"

module tpbp_emit #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  tpbp_pkg::load_t        load_data_i,
  input  logic [OFFSET_BITS-1:0] load_off_i,
  output logic                   load_ready_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [7:0]             m_byte_o,
  output logic [15:0]            m_off_o,
  output logic                   m_has_o,
  output logic                   m_last_o
);

  logic                        valid_q, valid_d;
  logic [tpbp_pkg::WordW-1:0]  word_q, word_d;
  logic [tpbp_pkg::BeatW-1:0]  beats_q, beats_d;
  logic                        has_q, has_d;
  logic [OFFSET_BITS-1:0]      off_q, off_d;
  logic [OFFSET_BITS+15:0]     off_ext;
  logic                        xfer;
  logic                        final_beat;

  assign xfer         = valid_q && m_tready_i;
  assign final_beat   = (beats_q == 3'd1);
  assign load_ready_o = !valid_q || (m_tready_i && final_beat);

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    beats_d = beats_q;
    has_d   = has_q;
    off_d   = off_q;
    if (load_i) begin
      valid_d = 1'b1;
      word_d  = load_data_i.word;
      beats_d = load_data_i.beats;
      has_d   = load_data_i.has_byte;
      off_d   = load_off_i;
    end else if (xfer) begin
      if (final_beat) begin
        valid_d = 1'b0;
      end
      word_d  = word_q >> 8;
      beats_d = beats_q - 3'd1;
      off_d   = off_q + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beats_q <= '0;
    end else begin
      valid_q <= valid_d;
      beats_q <= beats_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    has_q  <= has_d;
    off_q  <= off_d;
  end

  assign off_ext    = {16'd0, off_q};
  assign m_tvalid_o = valid_q;
  assign m_byte_o   = word_q[7:0];
  assign m_off_o    = off_ext[15:0];
  assign m_has_o    = has_q;
  assign m_last_o   = final_beat;

  `ASSERT_IMPL(a_beats_range, clk_i, rst_ni, valid_q, (beats_q != 3'd0) && (beats_q <= 3'd4))
  `ASSERT_IMPL(a_empty_single, clk_i, rst_ni, valid_q && !has_q, final_beat && (word_q[7:0] == 8'd0))
  `ASSERT_IMPL(a_load_free, clk_i, rst_ni, load_i, load_ready_o)
  `ASSERT_NEXT(a_more_beats, clk_i, rst_ni, xfer && !final_beat && !load_i, valid_q)

endmodule

// ===== hw/rtl/tracker_pattern_bit_packer.sv =====
// Top level of the tracker pattern bit packer: input register, bit accumulator, output
//
// Input stream (s_axis): one record per transfer, command in tuser, fields in tdata.
// Output stream (m_axis): one completed byte per transfer, with the running byte
// offset in tdata, has_byte in tuser and tlast on the final byte of a record.
// A record is held in an input register, merged with the pending partial byte
// there and loaded into the result register once that register can take it; its
// first byte is then offered from the result register. A record yields zero to four
// bytes (four at most, for a track line); the result register sends one per cycle
// while the receiver is ready. The next record waits in the input register while
// the last byte of the previous one is taken. Records that yield nothing do not
// wait for the result register.
// Align emits the padded partial byte, or a single has_byte=0 result when no
// bits are pending. Restart clears the pending byte and the offset.
// Reset clears pending state, offset and both valid flags; no clearing pass.
// When the receiver stalls, the current byte holds and the input side fills its
// register and then drops tready.
module tracker_pattern_bit_packer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // chunk_data, chunk_width, pattern, transpose, note, instrument,
  // effect_char, effect_param, zero pad
  input  logic [71:0] s_axis_tdata_i,
  // command
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // data_byte, offset
  output logic [23:0] m_axis_tdata_o,
  // has_byte
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic                          in_valid_q, in_valid_d;
  logic [tpbp_pkg::InDataW-1:0]  in_data_q;
  logic [2:0]                    in_user_q;
  logic [7:0]                    pend_bits_q, pend_bits_d;
  logic [2:0]                    pend_cnt_q, pend_cnt_d;
  logic [OFFSET_BITS-1:0]        boff_q, boff_d;

  tpbp_pkg::cmd_e                cmd;
  tpbp_pkg::enc_t                enc;
  tpbp_pkg::load_t               load_data;
  logic [tpbp_pkg::AccW-1:0]     acc;
  logic [tpbp_pkg::AccW-1:0]     rest;
  logic [5:0]                    total;
  logic [2:0]                    nbytes;
  logic                          empty_align;
  logic                          do_emit;
  logic                          load_ready;
  logic                          consume;
  logic [OFFSET_BITS-1:0]        load_off;
  logic [7:0]                    m_byte;
  logic [15:0]                   m_off;

  assign cmd = tpbp_pkg::cmd_e'(in_user_q);

  tpbp_encode u_encode (
    .cmd_i          (cmd),
    .chunk_data_i   (in_data_q[15:0]),
    .chunk_width_i  (in_data_q[20:16]),
    .pattern_i      (in_data_q[28:21]),
    .transpose_i    (in_data_q[36:29]),
    .note_i         (in_data_q[43:37]),
    .instrument_i   (in_data_q[51:44]),
    .effect_char_i  (in_data_q[59:52]),
    .effect_param_i (in_data_q[67:60]),
    .pend_cnt_i     (pend_cnt_q),
    .enc_o          (enc)
  );

  assign acc    = {32'd0, pend_bits_q} | ({8'd0, enc.bits} << pend_cnt_q);
  assign total  = {3'd0, pend_cnt_q} + {1'b0, enc.len};
  assign nbytes = total[5:3];
  assign rest   = acc >> {nbytes, 3'd0};

  assign empty_align = (cmd == tpbp_pkg::CMD_ALIGN) && (pend_cnt_q == 3'd0);
  assign do_emit     = (nbytes != 3'd0) || empty_align;
  assign consume     = in_valid_q && (!do_emit || load_ready);

  assign load_data.word     = acc[tpbp_pkg::WordW-1:0];
  assign load_data.beats    = empty_align ? 3'd1 : nbytes;
  assign load_data.has_byte = !empty_align;
  assign load_off           = empty_align ? boff_q : boff_q + OFFSET_BITS'(1);

  assign s_axis_tready_o = !in_valid_q || consume;

  always_comb begin
    in_valid_d  = in_valid_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    boff_d      = boff_q;
    if (consume) begin
      in_valid_d = 1'b0;
      if (cmd == tpbp_pkg::CMD_RESTART) begin
        pend_bits_d = '0;
        pend_cnt_d  = '0;
        boff_d      = '0;
      end else begin
        pend_bits_d = rest[7:0];
        pend_cnt_d  = total[2:0];
        boff_d      = boff_q + OFFSET_BITS'(nbytes);
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      boff_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      boff_q      <= boff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
  end

  tpbp_emit #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (consume && do_emit),
    .load_data_i  (load_data),
    .load_off_i   (load_off),
    .load_ready_o (load_ready),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_byte_o     (m_byte),
    .m_off_o      (m_off),
    .m_has_o      (m_axis_tuser_o),
    .m_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {m_off, m_byte};

endmodule

// ===== verif/tracker_pattern_bit_packer_test.sv =====
// Self-checking testbench for the tracker pattern bit packer: record stream in, byte stream checked
`timescale 1ns / 100ps

module tracker_pattern_bit_packer_test;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_WAIT = 8;
  localparam int unsigned RANDOM_RECORDS = 147;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [8*13-1:0] EFFECT_CHARS = "0dfijlmtvw~+=";

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] chunk_data;
    logic [4:0]  chunk_width;
    logic [7:0]  pattern;
    logic [7:0]  transpose;
    logic [6:0]  note;
    logic [7:0]  instrument;
    logic [7:0]  effect_char;
    logic [7:0]  effect_param;
  } record_t;

  typedef struct packed {
    logic        last;
    logic [15:0] offset;
    logic        has_byte;
    logic [7:0]  data;
  } out_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_axis_tready_o;
  logic [71:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_axis_tvalid_o;
  logic        m_ready;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        calm;

  tracker_pattern_bit_packer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  class bitstream_scoreboard;
    out_byte_t   expected_bytes[$];
    logic [7:0]  pend_bits;
    int          pend_cnt;
    logic [15:0] byte_count;
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      pend_bits = '0;
      pend_cnt = 0;
      byte_count = '0;
    endfunction

    function logic [3:0] effect_code(logic [7:0] ch);
      for (int i = 0; i < 13; i++)
        if (ch == EFFECT_CHARS[8*(12-i) +: 8]) return i[3:0];
      return 4'd0;
    endfunction

    function void push_byte(logic [7:0] d, logic h);
      out_byte_t e;
      e.data = d;
      e.has_byte = h;
      e.offset = byte_count;
      e.last = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void shift_in(logic [15:0] value, int width);
      for (int i = 0; i < width; i++) begin
        if (value[i]) pend_bits[pend_cnt] = 1'b1;
        pend_cnt++;
        if (pend_cnt == 8) begin
          byte_count++;
          push_byte(pend_bits, 1'b1);
          pend_bits = '0;
          pend_cnt = 0;
        end
      end
    endfunction

    // note an accepted record and queue the bytes it completes
    function void take_record(record_t r);
      int         queued;
      logic [3:0] code;
      queued = expected_bytes.size();
      code = effect_code(r.effect_char);
      case (r.cmd)
        tpbp_pkg::CMD_RESTART: clear();
        tpbp_pkg::CMD_CHUNK:
          shift_in(r.chunk_data, (r.chunk_width > 16) ? 16 : int'(r.chunk_width));
        tpbp_pkg::CMD_SONG: begin
          shift_in(16'(r.transpose != 0), 1);
          shift_in(16'(r.pattern), 6);
          if (r.transpose != 0) shift_in(16'(r.transpose), 4);
        end
        tpbp_pkg::CMD_INSTR: begin
          shift_in(16'(code), 8);
          shift_in(16'(r.effect_param), 8);
        end
        tpbp_pkg::CMD_TRACK: begin
          shift_in(16'(r.note != 0), 1);
          shift_in(16'(r.instrument != 0), 1);
          shift_in(16'(code != 0), 1);
          if (r.note != 0) shift_in(16'(r.note), 7);
          if (r.instrument != 0) shift_in(16'(r.instrument), 4);
          if (code != 0) begin
            shift_in(16'(code), 4);
            shift_in(16'(r.effect_param), 8);
          end
        end
        tpbp_pkg::CMD_ALIGN: begin
          if (pend_cnt != 0) begin
            byte_count++;
            push_byte(pend_bits, 1'b1);
            pend_bits = '0;
            pend_cnt = 0;
          end else begin
            push_byte(8'd0, 1'b0);
          end
        end
        default: ;
      endcase
      if (expected_bytes.size() > queued) expected_bytes[$].last = 1'b1;
    endfunction

    function void check_byte(out_byte_t got);
      out_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected byte: data %02h has %0b offset %0d last %0b",
                   got.data, got.has_byte, got.offset, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"byte mismatch: exp data %02h has %0b offset %0d last %0b, ",
                    "got data %02h has %0b offset %0d last %0b"},
                   want.data, want.has_byte, want.offset, want.last,
                   got.data, got.has_byte, got.offset, got.last);
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  bitstream_scoreboard sb = new();

  function automatic record_t rec(logic [2:0] cmd, logic [15:0] cdata, logic [4:0] cwidth,
                                  logic [7:0] pat, logic [7:0] tr, logic [6:0] nt,
                                  logic [7:0] ins, logic [7:0] ch, logic [7:0] prm);
    record_t r;
    r.cmd = cmd;
    r.chunk_data = cdata;
    r.chunk_width = cwidth;
    r.pattern = pat;
    r.transpose = tr;
    r.note = nt;
    r.instrument = ins;
    r.effect_char = ch;
    r.effect_param = prm;
    return r;
  endfunction

  function automatic record_t random_record();
    record_t r;
    int      pick;
    r.chunk_data = 16'($urandom);
    r.chunk_width = ($urandom_range(9, 0) == 0) ? 5'($urandom_range(31, 0))
                                                : 5'($urandom_range(16, 1));
    r.pattern = 8'($urandom);
    r.transpose = ($urandom_range(3, 0) == 0) ? 8'd0 : 8'($urandom);
    r.note = ($urandom_range(3, 0) == 0) ? 7'd0 : 7'($urandom);
    r.instrument = ($urandom_range(3, 0) == 0) ? 8'd0 : 8'($urandom);
    case ($urandom_range(3, 0))
      0: r.effect_char = 8'd0;
      1: r.effect_char = 8'($urandom);
      default: r.effect_char = EFFECT_CHARS[8*$urandom_range(12, 0) +: 8];
    endcase
    r.effect_param = 8'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 3) r.cmd = tpbp_pkg::CMD_RESTART;
    else if (pick < 23) r.cmd = tpbp_pkg::CMD_CHUNK;
    else if (pick < 40) r.cmd = tpbp_pkg::CMD_SONG;
    else if (pick < 55) r.cmd = tpbp_pkg::CMD_INSTR;
    else if (pick < 85) r.cmd = tpbp_pkg::CMD_TRACK;
    else if (pick < 95) r.cmd = tpbp_pkg::CMD_ALIGN;
    else r.cmd = pick[0] ? CMD_SPARE_A : CMD_SPARE_B;
    return r;
  endfunction

  task automatic send_record(input record_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(MAX_WAIT, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata = {4'd0, r.effect_param, r.effect_char, r.instrument, r.note,
               r.transpose, r.pattern, r.chunk_width, r.chunk_data};
    s_tuser = r.cmd;
    s_valid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_record(r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tracker_pattern_bit_packer_test NOT OK");
    $finish;
  end

  // byte sink with random back-pressure
  initial begin
    out_byte_t got;
    int        stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(MAX_WAIT, 0);
      @(negedge clk_i);
      if (stall != 0) begin
        m_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got = {m_axis_tlast_o, m_axis_tdata_o[23:8], m_axis_tuser_o, m_axis_tdata_o[7:0]};
      sb.check_byte(got);
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_ready = 1'b0;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_record(rec(tpbp_pkg::CMD_RESTART, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_ALIGN, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_CHUNK, 16'h0001, 5'd1, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_CHUNK, 16'hFFFF, 5'd16, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_CHUNK, 16'hFFFF, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_CHUNK, 16'hA5C3, 5'd31, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_CHUNK, 16'h0000, 5'd17, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_ALIGN, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_SONG, 16'h0000, 5'd0, 8'hFF, 8'h00, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_SONG, 16'h0000, 5'd0, 8'h2A, 8'hFF, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_INSTR, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, "=", 8'hFF));
    send_record(rec(tpbp_pkg::CMD_INSTR, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'hFF, 8'h00));
    send_record(rec(tpbp_pkg::CMD_INSTR, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'h00, 8'h80));
    send_record(rec(tpbp_pkg::CMD_TRACK, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'h00, 8'h00));
    send_record(rec(tpbp_pkg::CMD_TRACK, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd127, 8'hFF, "~",
                    8'hFF));
    send_record(rec(tpbp_pkg::CMD_TRACK, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd1, 8'h00, "0", 8'h55));
    send_record(rec(tpbp_pkg::CMD_TRACK, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'h10, "d", 8'h3C));
    send_record(rec(CMD_SPARE_A, 16'hFFFF, 5'd16, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(CMD_SPARE_B, 16'hFFFF, 5'd16, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_ALIGN, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_CHUNK, 16'h0007, 5'd3, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_RESTART, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));
    send_record(rec(tpbp_pkg::CMD_ALIGN, 16'h0000, 5'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0));

    for (int i = 0; i < RANDOM_RECORDS; i++) begin
      calm = (i % 50) >= 40;
      send_record(random_record());
    end
    calm = 1'b0;

    @(negedge clk_i);
    s_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tracker_pattern_bit_packer_test OK");
    else
      $display("tracker_pattern_bit_packer_test NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tpbp_pkg.sv
hw/rtl/tpbp_encode.sv
hw/rtl/tpbp_emit.sv
hw/rtl/tracker_pattern_bit_packer.sv
verif/tracker_pattern_bit_packer_test.sv
